FILE: sv/pdce_pkg.sv
package pdce_pkg;

  // Field widths.
  localparam int COORD_W = 29;
  localparam int DELTA_W = COORD_W + 1;
  localparam int CODE_W  = DELTA_W + 1;
  localparam int CHAR_W  = 7;
  localparam int CHUNK_W = 5;

  // Character encoding constants.
  localparam logic [CHUNK_W-1:0] CHUNK_MASK = 5'h1f;
  localparam logic [CHAR_W-1:0]  CHUNK_FLAG = 7'h20;
  localparam logic [CHAR_W-1:0]  CHAR_BIAS  = 7'd63;
  localparam logic [CHAR_W-1:0]  BACKSLASH  = 7'd92;

  // Which coordinate the sequencer is working on.
  localparam logic SEL_LAT = 1'b0;
  localparam logic SEL_LON = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_EMIT = 4'b0100,
    S_DUP  = 4'b1000
  } state_t;

endpackage

FILE: sv/pdce_point_if.sv
interface pdce_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdce_pkg::COORD_W-1:0]   point_lat;
  logic signed [pdce_pkg::COORD_W-1:0]   point_lon;
  logic                                  line_start;
  logic                                  keep;

  modport source (output valid, point_lat, point_lon, line_start, keep, input ready);
  modport sink   (input valid, point_lat, point_lon, line_start, keep, output ready);
endinterface

FILE: sv/pdce_char_if.sv
interface pdce_char_if;
  logic                          valid;
  logic                          ready;
  logic [pdce_pkg::CHAR_W-1:0]   out_char;
  logic                          run_last;

  modport source (output valid, out_char, run_last, input ready);
  modport sink   (input valid, out_char, run_last, output ready);
endinterface

FILE: sv/polyline_delta_char_encoder_unit.sv
// Polyline delta character encoder.
// The points channel takes one fixed-point point (latitude, longitude) with a
// line start flag and a keep flag. The chars channel returns the encoded
// polyline characters of that point, latitude first, with run_last set on
// the last character of the point. A skipped point (keep and line_start both
// low) returns nothing.
// One subtractor and one chunk shifter are shared by both coordinates under
// a small sequencer. A kept point is accepted in the idle state; then per
// coordinate a calc state forms the delta and its zig-zag code, an emit state
// sends one to seven chunk characters and a dup state doubles a backslash.
// A skipped point is dropped while the sequencer stays idle. The first
// character is registered from the emit state after the first calc state.
// The points channel is ready only while the sequencer is idle.
// A one-entry output register sits on the chars channel; while the receiver
// stalls it holds its character and the sequencer waits.
// Reset clears the last encoded point to zero and empties the output
// register.
module polyline_delta_char_encoder_unit (
  input  logic             clk,
  input  logic             rst,
  pdce_point_if.sink       points,
  pdce_char_if.source      chars
);

  pdce_pkg::state_t state, state_next;

  logic signed [pdce_pkg::COORD_W-1:0] hold_lat;
  logic signed [pdce_pkg::COORD_W-1:0] hold_lon;
  logic                                hold_start;
  logic signed [pdce_pkg::COORD_W-1:0] prev_lat;
  logic signed [pdce_pkg::COORD_W-1:0] prev_lon;
  logic                                fsel;
  logic [pdce_pkg::CODE_W-1:0]         code;

  logic                                out_valid;
  logic [pdce_pkg::CHAR_W-1:0]         out_char;
  logic                                out_last;

  logic                                accept;
  logic                                out_free;
  logic signed [pdce_pkg::COORD_W-1:0] sub_a;
  logic signed [pdce_pkg::COORD_W-1:0] sub_b;
  logic signed [pdce_pkg::DELTA_W-1:0] delta;
  logic signed [pdce_pkg::CODE_W-1:0]  dbl;
  logic [pdce_pkg::CODE_W-1:0]         code_calc;
  logic                                more;
  logic [pdce_pkg::CHAR_W-1:0]         chr;

  assign accept   = points.valid && points.ready;
  assign out_free = !out_valid || chars.ready;

  assign points.ready   = (state == pdce_pkg::S_IDLE);
  assign chars.valid    = out_valid;
  assign chars.out_char = out_char;
  assign chars.run_last = out_last;

  // Shared subtractor and zig-zag mapping.
  always_comb begin
    sub_a     = (fsel == pdce_pkg::SEL_LON) ? hold_lon : hold_lat;
    sub_b     = hold_start ? '0 : ((fsel == pdce_pkg::SEL_LON) ? prev_lon : prev_lat);
    delta     = pdce_pkg::DELTA_W'(sub_a) - pdce_pkg::DELTA_W'(sub_b);
    dbl       = {delta, 1'b0};
    code_calc = dbl[pdce_pkg::CODE_W-1] ? ~dbl : dbl;
  end

  // Next character from the low chunk of the code.
  always_comb begin
    more = |code[pdce_pkg::CODE_W-1:pdce_pkg::CHUNK_W];
    chr  = pdce_pkg::CHAR_BIAS
         + {1'b0, more, code[pdce_pkg::CHUNK_W-1:0] & pdce_pkg::CHUNK_MASK};
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      pdce_pkg::S_IDLE: begin
        if (accept && (points.line_start || points.keep)) begin
          state_next = pdce_pkg::S_CALC;
        end
      end
      pdce_pkg::S_CALC: begin
        state_next = pdce_pkg::S_EMIT;
      end
      pdce_pkg::S_EMIT: begin
        if (out_free && !more) begin
          if (chr == pdce_pkg::BACKSLASH) begin
            state_next = pdce_pkg::S_DUP;
          end else if (fsel == pdce_pkg::SEL_LAT) begin
            state_next = pdce_pkg::S_CALC;
          end else begin
            state_next = pdce_pkg::S_IDLE;
          end
        end
      end
      pdce_pkg::S_DUP: begin
        if (out_free) begin
          state_next = (fsel == pdce_pkg::SEL_LAT) ? pdce_pkg::S_CALC : pdce_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pdce_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pdce_pkg::S_IDLE;
      out_valid <= 1'b0;
      prev_lat  <= '0;
      prev_lon  <= '0;
      fsel      <= pdce_pkg::SEL_LAT;
    end else begin
      state <= state_next;
      // The output register refills from the sequencer or empties when taken.
      if ((state == pdce_pkg::S_EMIT || state == pdce_pkg::S_DUP) && out_free) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      if (state == pdce_pkg::S_IDLE && accept) begin
        fsel <= pdce_pkg::SEL_LAT;
      end
      // The lon delta is the last use of the previous point.
      if (state == pdce_pkg::S_CALC && fsel == pdce_pkg::SEL_LON) begin
        prev_lat <= hold_lat;
        prev_lon <= hold_lon;
      end
      if (state == pdce_pkg::S_EMIT && out_free) begin
        if (!more && chr != pdce_pkg::BACKSLASH && fsel == pdce_pkg::SEL_LAT) begin
          fsel <= pdce_pkg::SEL_LON;
        end
      end
      if (state == pdce_pkg::S_DUP && out_free) begin
        if (fsel == pdce_pkg::SEL_LAT) begin
          fsel <= pdce_pkg::SEL_LON;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_lat   <= points.point_lat;
      hold_lon   <= points.point_lon;
      hold_start <= points.line_start;
    end
    if (state == pdce_pkg::S_CALC) begin
      code <= code_calc;
    end
    if (state == pdce_pkg::S_EMIT && out_free) begin
      code     <= code >> pdce_pkg::CHUNK_W;
      out_char <= chr;
      out_last <= !more && chr != pdce_pkg::BACKSLASH && fsel == pdce_pkg::SEL_LON;
    end
    if (state == pdce_pkg::S_DUP && out_free) begin
      out_char <= pdce_pkg::BACKSLASH;
      out_last <= (fsel == pdce_pkg::SEL_LON);
    end
  end

  // A coded point always starts with a delta computation.
  a_start_calc: assert property (@(posedge clk) disable iff (rst)
    accept && (points.line_start || points.keep) |=> state == pdce_pkg::S_CALC)
    else $error("kept point did not start the sequencer");

  // A skipped point leaves the last encoded point alone.
  a_skip_stable: assert property (@(posedge clk) disable iff (rst)
    accept && !points.line_start && !points.keep |=> $stable(prev_lat) && $stable(prev_lon))
    else $error("skipped point changed the stored point");

  // The doubled backslash follows a backslash already in the output register.
  a_dup_char: assert property (@(posedge clk) disable iff (rst)
    state == pdce_pkg::S_DUP |-> out_valid && out_char == pdce_pkg::BACKSLASH && !out_last)
    else $error("backslash doubling without a pending backslash");

  // Every character offered lies at or above the character bias.
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char >= pdce_pkg::CHAR_BIAS)
    else $error("character below the encoded range");

endmodule
